// ===== rtl/xor_binary_trie_set_assert.svh =====
// Assertion macros for the XOR binary trie set.
// Used by rtl/xor_binary_trie_set.sv, which provides clk and rst_n.
`ifndef XOR_BINARY_TRIE_SET_ASSERT_SVH
`define XOR_BINARY_TRIE_SET_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define XBTS_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// A condition that must hold whenever the antecedent holds.
`define XBTS_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/xbts_pkg.sv =====
// Shared constants for the XOR binary trie set: key and tree widths, port widths
// and operation codes. Depends on nothing.
`default_nettype none

package xbts_pkg;

    // Key width held by the tree.
    localparam int KEY_BITS = 10;

    // Node index width: node 1 is the root, leaves are 2**KEY_BITS upwards.
    localparam int NODE_W = KEY_BITS + 1;
    // A counter must hold the full set size, 2**KEY_BITS.
    localparam int CNT_W  = KEY_BITS + 1;
    localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

    // Port field widths.
    localparam int OPC_W  = 3;
    localparam int KEY_W  = 10;
    localparam int RANK_W = 10;
    localparam int VAL_W  = 10;
    localparam int SIZE_W = 11;

    // Width used to compare a rank against the set size without loss.
    localparam int CMP_W  = (RANK_W > CNT_W) ? RANK_W + 1 : CNT_W + 1;

    localparam logic [CNT_W-1:0] SET_CAP = CNT_W'(1) << KEY_BITS;

    // Operation codes.
    localparam logic [OPC_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [OPC_W-1:0] OP_ERASE   = 3'd1;
    localparam logic [OPC_W-1:0] OP_FIND    = 3'd2;
    localparam logic [OPC_W-1:0] OP_XOR_ALL = 3'd3;
    localparam logic [OPC_W-1:0] OP_KTH_MIN = 3'd4;
    localparam logic [OPC_W-1:0] OP_KTH_MAX = 3'd5;
    localparam logic [OPC_W-1:0] OP_MIN_XOR = 3'd6;
    localparam logic [OPC_W-1:0] OP_MAX_XOR = 3'd7;

endpackage

`default_nettype wire

// ===== rtl/xor_binary_trie_set.sv =====
// XOR binary trie set: prefix counter memory, sequencer and output register.
// Depends on xbts_pkg and the assertion macros in xor_binary_trie_set_assert.svh.
//
// Usage. Operations arrive on the input channel (in_valid, in_ready, with opcode,
// key and rank) and each produces exactly one result on the output channel
// (out_valid, out_ready, with found, value, set_size and rank_error). A transfer
// takes place on a rising edge where valid and ready are both high.
// After reset the counter memory is swept to zero, one node per cycle, across all
// 2**(KEY_BITS+1) = 2048 nodes; in_ready stays low throughout.
// From the input transfer, xor_all and any query that reports a rank error go
// straight to the result; find reads the leaf counter; the rank walks read one
// counter per tree level; insert and erase read the leaf and, unless the set is
// left unchanged, then update every counter on the path below the root.
// in_ready rises on the edge that loads the result, so a new item is taken only
// once the previous one has reached the output register. The pace is set by the
// single counter memory, which serves one tree level per cycle: one read per level
// for the rank walks, and one read plus one write per level, overlapped, for the counter updates.
// The output register holds one result, so a new item may be taken while the
// previous result waits; if the receiver stalls for longer, the finished result
// is held inside the block and in_ready stays low until the register frees up.

`default_nettype none
`include "xor_binary_trie_set_assert.svh"

module xor_binary_trie_set (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [xbts_pkg::OPC_W-1:0]  opcode,
    input  wire logic [xbts_pkg::KEY_W-1:0]  key,
    input  wire logic [xbts_pkg::RANK_W-1:0] rank,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             found,
    output logic [xbts_pkg::VAL_W-1:0]       value,
    output logic [xbts_pkg::SIZE_W-1:0]      set_size,
    output logic                             rank_error
);

    import xbts_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_CLEAR     = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_LOOKUP    = 3'd2;
    localparam logic [2:0] S_CHECK     = 3'd3;
    localparam logic [2:0] S_UPDATE    = 3'd4;
    localparam logic [2:0] S_SEL_START = 3'd5;
    localparam logic [2:0] S_SEL       = 3'd6;
    localparam logic [2:0] S_DONE      = 3'd7;

    localparam int MEM_DEPTH = 1 << NODE_W;

    // Prefix counter memory. Node 0 is never used; the root count is kept
    // in size_reg rather than in the memory.
    logic [CNT_W-1:0] mem [MEM_DEPTH];

    logic [2:0]          state_reg,     state_next;
    logic [NODE_W-1:0]   clr_cnt_reg,   clr_cnt_next;
    logic [OPC_W-1:0]    op_reg,        op_next;
    logic [KEY_BITS-1:0] stored_reg,    stored_next;
    logic [KEY_BITS-1:0] sel_mask_reg,  sel_mask_next;
    logic [KEY_BITS-1:0] mask_reg,      mask_next;
    logic [KEY_BITS-1:0] res_reg,       res_next;
    logic [CNT_W-1:0]    k_reg,         k_next;
    logic [CNT_W-1:0]    size_reg,      size_next;
    logic [NODE_W-1:0]   node_reg,      node_next;
    logic [LVL_W-1:0]    lvl_reg,       lvl_next;
    logic                found_int_reg, found_int_next;
    logic                err_int_reg,   err_int_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg, out_found_next;
    logic [VAL_W-1:0]    out_value_reg, out_value_next;
    logic [SIZE_W-1:0]   out_size_reg,  out_size_next;
    logic                out_err_reg,   out_err_next;

    logic [CNT_W-1:0]    rdata_reg;
    logic [NODE_W-1:0]   rd_addr;
    logic                mem_we;
    logic [NODE_W-1:0]   mem_waddr;
    logic [CNT_W-1:0]    mem_wdata;

    // Operand preparation at the input transfer.
    logic [KEY_BITS-1:0] key_k;
    logic [CMP_W-1:0]    rank_cmp;
    logic [CMP_W-1:0]    size_cmp;
    logic                rank_big;
    logic                size_zero;

    // Counter update along the path of a stored key.
    logic                is_insert;
    logic                present;
    logic                do_update;
    logic [CNT_W-1:0]    upd_val;
    logic [NODE_W-1:0]   parent;

    // One level of the rank walk.
    logic                sel_wb;
    logic                sel_take;
    logic                sel_bit;
    logic [NODE_W-1:0]   sel_node;
    logic [CNT_W-1:0]    sel_k;
    logic [KEY_BITS-1:0] sel_res;
    logic [LVL_W-1:0]    lvl_dec;

    assign key_k     = KEY_BITS'(key);
    assign rank_cmp  = CMP_W'(rank);
    assign size_cmp  = CMP_W'(size_reg);
    assign rank_big  = rank_cmp >= size_cmp;
    assign size_zero = size_reg == '0;

    assign is_insert = op_reg == OP_INSERT;
    assign present   = rdata_reg != '0;
    assign do_update = is_insert ? !present : present;
    assign upd_val   = is_insert ? CNT_W'(rdata_reg + 1'b1) : CNT_W'(rdata_reg - 1'b1);
    assign parent    = node_reg >> 1;

    // The left child on the mask bit holds keys whose result bit is zero.
    assign sel_wb    = sel_mask_reg[lvl_reg];
    assign sel_take  = rdata_reg > k_reg;
    assign sel_bit   = !sel_take;
    assign sel_node  = NODE_W'({node_reg, sel_wb ^ sel_bit});
    assign sel_k     = sel_take ? k_reg : CNT_W'(k_reg - rdata_reg);
    assign sel_res   = KEY_BITS'({res_reg, sel_bit});
    assign lvl_dec   = LVL_W'(lvl_reg - 1'b1);

    assign in_ready   = state_reg == S_IDLE;
    assign out_valid  = out_valid_reg;
    assign found      = out_found_reg;
    assign value      = out_value_reg;
    assign set_size   = out_size_reg;
    assign rank_error = out_err_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        op_next        = op_reg;
        stored_next    = stored_reg;
        sel_mask_next  = sel_mask_reg;
        mask_next      = mask_reg;
        res_next       = res_reg;
        k_next         = k_reg;
        size_next      = size_reg;
        node_next      = node_reg;
        lvl_next       = lvl_reg;
        found_int_next = found_int_reg;
        err_int_next   = err_int_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_value_next = out_value_reg;
        out_size_next  = out_size_reg;
        out_err_next   = out_err_reg;
        rd_addr        = '0;
        mem_we         = 1'b0;
        mem_waddr      = node_reg;
        mem_wdata      = upd_val;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = NODE_W'(clr_cnt_reg + 1'b1);
                if (&clr_cnt_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next        = opcode;
                    stored_next    = key_k ^ mask_reg;
                    found_int_next = 1'b0;
                    err_int_next   = 1'b0;
                    res_next       = '0;
                    node_next      = NODE_W'(1);
                    lvl_next       = LVL_W'(KEY_BITS - 1);
                    sel_mask_next  = mask_reg;
                    case (opcode)
                        OP_INSERT, OP_ERASE, OP_FIND:
                        begin
                            state_next = S_LOOKUP;
                        end
                        OP_XOR_ALL:
                        begin
                            mask_next  = mask_reg ^ key_k;
                            state_next = S_DONE;
                        end
                        OP_KTH_MIN:
                        begin
                            k_next       = CNT_W'(rank);
                            err_int_next = rank_big;
                            state_next   = rank_big ? S_DONE : S_SEL_START;
                        end
                        OP_KTH_MAX:
                        begin
                            k_next       = CNT_W'(size_cmp - rank_cmp - 1'b1);
                            err_int_next = rank_big;
                            state_next   = rank_big ? S_DONE : S_SEL_START;
                        end
                        OP_MIN_XOR:
                        begin
                            k_next        = '0;
                            sel_mask_next = mask_reg ^ key_k;
                            err_int_next  = size_zero;
                            state_next    = size_zero ? S_DONE : S_SEL_START;
                        end
                        default:
                        begin
                            k_next        = CNT_W'(size_reg - 1'b1);
                            sel_mask_next = mask_reg ^ key_k;
                            err_int_next  = size_zero;
                            state_next    = size_zero ? S_DONE : S_SEL_START;
                        end
                    endcase
                end
            end

            S_LOOKUP:
            begin
                rd_addr    = NODE_W'({1'b1, stored_reg});
                node_next  = NODE_W'({1'b1, stored_reg});
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (op_reg == OP_FIND)
                begin
                    found_int_next = present;
                    state_next     = S_DONE;
                end
                else if (do_update)
                begin
                    // Leaf write overlaps the read of its parent.
                    mem_we    = 1'b1;
                    size_next = is_insert ? CNT_W'(size_reg + 1'b1)
                                          : CNT_W'(size_reg - 1'b1);
                    if (parent == NODE_W'(1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_addr    = parent;
                        node_next  = parent;
                        state_next = S_UPDATE;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_UPDATE:
            begin
                mem_we = 1'b1;
                if (parent == NODE_W'(1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_addr   = parent;
                    node_next = parent;
                end
            end

            S_SEL_START:
            begin
                rd_addr    = NODE_W'({node_reg, sel_wb});
                state_next = S_SEL;
            end

            S_SEL:
            begin
                node_next = sel_node;
                k_next    = sel_k;
                res_next  = sel_res;
                if (lvl_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_next = lvl_dec;
                    rd_addr  = NODE_W'({sel_node, sel_mask_reg[lvl_dec]});
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_int_reg;
                    out_value_next = VAL_W'(res_reg);
                    out_size_next  = SIZE_W'(size_reg);
                    out_err_next   = err_int_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            mask_reg      <= '0;
            size_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            mask_reg      <= mask_next;
            size_reg      <= size_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        stored_reg    <= stored_next;
        sel_mask_reg  <= sel_mask_next;
        res_reg       <= res_next;
        k_reg         <= k_next;
        node_reg      <= node_next;
        lvl_reg       <= lvl_next;
        found_int_reg <= found_int_next;
        err_int_reg   <= err_int_next;
        out_found_reg <= out_found_next;
        out_value_reg <= out_value_next;
        out_size_reg  <= out_size_next;
        out_err_reg   <= out_err_next;
    end

    // Counter memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    `XBTS_ASSERT_ALWAYS(a_size_cap, size_reg <= SET_CAP, "set size beyond capacity")
    `XBTS_ASSERT_IMPLY(a_we_state, mem_we, state_reg == S_CLEAR || state_reg == S_CHECK || state_reg == S_UPDATE, "counter write outside clear or update")
    `XBTS_ASSERT_IMPLY(a_update_node, state_reg == S_UPDATE, node_reg > NODE_W'(1), "update walk reached the root")
    `XBTS_ASSERT_IMPLY(a_err_value, out_valid_reg && out_err_reg, out_value_reg == '0 && !out_found_reg, "rank error with a non-zero result")

endmodule

`default_nettype wire

// ===== test/xor_binary_trie_set_tb.sv =====
// Self-checking testbench for the XOR binary trie set: random and directed operations
// against a built-in model of the prefix counter tree and the global XOR mask.
// Depends on xbts_pkg and the RTL top level xor_binary_trie_set.
`default_nettype none

module xor_binary_trie_set_tb;
    import xbts_pkg::*;

    // Cycles without any transfer before the run is declared hung. The clearing
    // sweep after reset alone covers all 2048 counter nodes.
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_GAP     = 10;
    localparam int NODES       = 1 << NODE_W;
    localparam int KEYS        = 1 << KEY_BITS;

    // Shapes of the random phases.
    localparam int PH_GROW   = 0;
    localparam int PH_SHRINK = 1;
    localparam int PH_MIXED  = 2;

    typedef struct {
        logic [OPC_W-1:0]  opcode;
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
        bit                drain;   // hold this one back until every result is in
    } trie_op_t;

    typedef struct packed {
        logic              found;
        logic [VAL_W-1:0]  value;
        logic [SIZE_W-1:0] set_size;
        logic              rank_error;
    } trie_answer_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [OPC_W-1:0]  opcode = OP_FIND;
    logic [KEY_W-1:0]  key = '0;
    logic [RANK_W-1:0] rank = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              found;
    logic [VAL_W-1:0]  value;
    logic [SIZE_W-1:0] set_size;
    logic              rank_error;

    xor_binary_trie_set DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .key        (key),
        .rank       (rank),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .value      (value),
        .set_size   (set_size),
        .rank_error (rank_error)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Operations waiting to be driven, and answers waiting to come back.
    trie_op_t     op_backlog[$];
    trie_answer_t trie_answers[$];

    // Model of the block: one counter per tree node (node 1 is the root, the
    // leaves start at 2**KEY_BITS) and the XOR mask applied to every key.
    logic [CNT_W-1:0]    node_cnt [1:NODES-1];
    logic [KEY_BITS-1:0] mask_now;

    // Shadow of the set kept while the stimulus is built, so that ranks can be
    // aimed at the current size. It is never used for checking.
    logic [KEYS-1:0]     gen_held;
    logic [KEY_BITS-1:0] gen_mask;
    int                  gen_size;

    int  errors = 0;
    int  idle_cycles = 0;
    bit  in_took = 1'b0;
    bit  out_took = 1'b0;
    int  send_wait = 0;
    int  recv_wait = 0;
    bit  send_quiet = 1'b0;
    bit  recv_quiet = 1'b0;
    trie_op_t     next_op;
    trie_answer_t want;
    trie_answer_t got;

    // Adds one to, or takes one from, every counter on the path of a stored key.
    function automatic void adjust_path(input logic [KEY_BITS-1:0] stored, input bit up);
        int unsigned node;
        node = KEYS | 32'(stored);
        while (node >= 1)
        begin
            node_cnt[node] = up ? node_cnt[node] + 1'b1 : node_cnt[node] - 1'b1;
            node = node >> 1;
        end
    endfunction

    // Walks down the tree to the k-th smallest of (stored ^ m). The caller makes
    // sure that k is below the set size.
    function automatic logic [VAL_W-1:0] pick_rank(input int unsigned k,
                                                  input logic [KEY_BITS-1:0] m);
        int unsigned         node;
        int unsigned         pref;
        int unsigned         c;
        logic [KEY_BITS-1:0] res;
        node = 1;
        res  = '0;
        for (int i = KEY_BITS - 1; i >= 0; i--)
        begin
            pref = 2 * node + 32'(m[i]);
            c    = 32'(node_cnt[pref]);
            if (c > k)
            begin
                node = pref;
                res  = res << 1;
            end
            else
            begin
                k    = k - c;
                node = 2 * node + 32'(m[i] ^ 1'b1);
                res  = (res << 1) | 1'b1;
            end
        end
        return VAL_W'(res);
    endfunction

    // Applies one operation to the model and returns the answer it should give.
    function automatic trie_answer_t apply_trie_op(input logic [OPC_W-1:0] op,
                                                   input logic [KEY_W-1:0] k,
                                                   input logic [RANK_W-1:0] r);
        trie_answer_t        ans;
        logic [KEY_BITS-1:0] kbits;
        logic [KEY_BITS-1:0] stored;
        bit                  present;
        int unsigned         size;
        ans     = '0;
        kbits   = k[KEY_BITS-1:0];
        stored  = kbits ^ mask_now;
        present = node_cnt[KEYS | 32'(stored)] != 0;
        size    = 32'(node_cnt[1]);
        case (op)
            OP_INSERT:  if (!present) adjust_path(stored, 1'b1);
            OP_ERASE:   if (present) adjust_path(stored, 1'b0);
            OP_FIND:    ans.found = present;
            OP_XOR_ALL: mask_now = mask_now ^ kbits;
            OP_KTH_MIN:
                if (r >= size) ans.rank_error = 1'b1;
                else ans.value = pick_rank(32'(r), mask_now);
            OP_KTH_MAX:
                if (r >= size) ans.rank_error = 1'b1;
                else ans.value = pick_rank(size - 1 - 32'(r), mask_now);
            OP_MIN_XOR:
                if (size == 0) ans.rank_error = 1'b1;
                else ans.value = pick_rank(0, mask_now ^ kbits);
            default:
                if (size == 0) ans.rank_error = 1'b1;
                else ans.value = pick_rank(size - 1, mask_now ^ kbits);
        endcase
        ans.set_size = SIZE_W'(node_cnt[1]);
        return ans;
    endfunction

    function automatic void check_field(input string name, input logic [SIZE_W-1:0] exp_v,
                                        input logic [SIZE_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endfunction

    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Queues one operation and keeps the stimulus-side shadow of the set up to date.
    function automatic void add_op(input logic [OPC_W-1:0] op, input logic [KEY_W-1:0] k,
                                   input logic [RANK_W-1:0] r, input bit drain);
        trie_op_t            item;
        logic [KEY_BITS-1:0] stored;
        item.opcode = op;
        item.key    = k;
        item.rank   = r;
        item.drain  = drain;
        op_backlog.push_back(item);
        stored = k[KEY_BITS-1:0] ^ gen_mask;
        if (op == OP_INSERT && !gen_held[stored])
        begin
            gen_held[stored] = 1'b1;
            gen_size++;
        end
        else if (op == OP_ERASE && gen_held[stored])
        begin
            gen_held[stored] = 1'b0;
            gen_size--;
        end
        else if (op == OP_XOR_ALL)
            gen_mask = gen_mask ^ k[KEY_BITS-1:0];
    endfunction

    // Ranks are often small, often right at the edge of the current size, and
    // sometimes anywhere in the field's range.
    function automatic logic [RANK_W-1:0] draw_rank();
        int r;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            r = $urandom_range(0, 7);
        else if (pick < 7)
            r = gen_size - 2 + $urandom_range(0, 3);
        else
            r = $urandom_range(0, (1 << RANK_W) - 1);
        if (r < 0)
            r = 0;
        if (r > (1 << RANK_W) - 1)
            r = (1 << RANK_W) - 1;
        return RANK_W'(r);
    endfunction

    function automatic logic [OPC_W-1:0] query_op();
        case ($urandom_range(0, 5))
            0:       return OP_FIND;
            1:       return OP_XOR_ALL;
            2:       return OP_KTH_MIN;
            3:       return OP_KTH_MAX;
            4:       return OP_MIN_XOR;
            default: return OP_MAX_XOR;
        endcase
    endfunction

    // Sender. A new operation is put on the bus at a falling edge once the
    // previous one has been transferred and its drawn gap has run out. An
    // operation marked drain is held back until no answer is outstanding.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_took)
            begin
                if (send_wait > 0)
                begin
                    in_valid <= 1'b0;
                    send_wait--;
                end
                else if (op_backlog.size() != 0 &&
                         !(op_backlog[0].drain && trie_answers.size() != 0))
                begin
                    next_op = op_backlog.pop_front();
                    opcode   <= next_op.opcode;
                    key      <= next_op.key;
                    rank     <= next_op.rank;
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        send_quiet = ~send_quiet;
                    send_wait = draw_gap(send_quiet);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver. After each transfer a fresh stall is drawn; the stall counts
    // down whether or not a result is on offer, so the gaps land on every
    // phase of the block's work.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_took)
            begin
                if ($urandom_range(0, 39) == 0)
                    recv_quiet = ~recv_quiet;
                recv_wait = draw_gap(recv_quiet);
            end
            if (recv_wait > 0)
            begin
                out_ready <= 1'b0;
                recv_wait--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor. On each rising edge it checks a delivered result against the
    // oldest expected answer, then runs the model for an operation that is
    // transferred on the same edge, and keeps the watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_took  <= in_valid && in_ready;
            out_took <= out_valid && out_ready;
            if (out_valid && out_ready)
            begin
                if (trie_answers.size() == 0)
                begin
                    errors++;
                    $display("%0t: stray result, expected none, actual %0d %0d %0d %0d",
                             $time, found, value, set_size, rank_error);
                end
                else
                begin
                    want = trie_answers.pop_front();
                    got  = '{found, value, set_size, rank_error};
                    check_field("found", SIZE_W'(want.found), SIZE_W'(got.found));
                    check_field("value", SIZE_W'(want.value), SIZE_W'(got.value));
                    check_field("set_size", want.set_size, got.set_size);
                    check_field("rank_error", SIZE_W'(want.rank_error),
                                SIZE_W'(got.rank_error));
                end
            end
            if (in_valid && in_ready)
                trie_answers.push_back(apply_trie_op(opcode, key, rank));
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("xor_binary_trie_set_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        int order [KEYS];
        int j;
        int tmp;
        int kind;
        bit narrow;
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] k;
        logic [OPC_W-1:0] op;
        int pick;

        for (int n = 1; n < NODES; n++)
            node_cnt[n] = '0;
        mask_now = '0;
        gen_held = '0;
        gen_mask = '0;
        gen_size = 0;
        recv_wait = $urandom_range(0, MAX_GAP);

        // Directed part: every lookup and rank query on an empty set, duplicate insert, absent
        // erase, ranks on and past the edge of the set, the extreme keys and
        // ranks, and lookups through a non-zero mask.
        add_op(OP_FIND,    10'd0,    10'd0,    1'b0);
        add_op(OP_KTH_MIN, 10'd0,    10'd0,    1'b0);
        add_op(OP_KTH_MAX, 10'd1023, 10'd1023, 1'b0);
        add_op(OP_MIN_XOR, 10'd0,    10'd0,    1'b0);
        add_op(OP_MAX_XOR, 10'd1023, 10'd0,    1'b0);
        add_op(OP_INSERT,  10'd0,    10'd0,    1'b0);
        add_op(OP_INSERT,  10'd1023, 10'd0,    1'b0);
        add_op(OP_INSERT,  10'd1023, 10'd1023, 1'b0);
        add_op(OP_INSERT,  10'd512,  10'd0,    1'b0);
        add_op(OP_FIND,    10'd1023, 10'd0,    1'b0);
        add_op(OP_FIND,    10'd5,    10'd0,    1'b0);
        add_op(OP_ERASE,   10'd5,    10'd0,    1'b0);
        add_op(OP_KTH_MIN, 10'd0,    10'd0,    1'b0);
        add_op(OP_KTH_MIN, 10'd0,    10'd2,    1'b0);
        add_op(OP_KTH_MIN, 10'd0,    10'd3,    1'b0);
        add_op(OP_KTH_MAX, 10'd0,    10'd0,    1'b0);
        add_op(OP_KTH_MAX, 10'd0,    10'd1023, 1'b0);
        add_op(OP_MIN_XOR, 10'd1023, 10'd0,    1'b0);
        add_op(OP_MAX_XOR, 10'd0,    10'd0,    1'b0);
        add_op(OP_XOR_ALL, 10'd1023, 10'd0,    1'b0);
        add_op(OP_FIND,    10'd0,    10'd0,    1'b0);
        add_op(OP_INSERT,  10'd1,    10'd0,    1'b0);
        add_op(OP_KTH_MIN, 10'd0,    10'd0,    1'b1);
        add_op(OP_ERASE,   10'd1023, 10'd0,    1'b0);
        add_op(OP_XOR_ALL, 10'd1023, 10'd0,    1'b0);

        // Fill the set completely, in shuffled order, with queries mixed in.
        for (int i = 0; i < KEYS; i++)
            order[i] = i;
        for (int i = KEYS - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < KEYS; i++)
        begin
            add_op(OP_INSERT, KEY_W'(order[i]) ^ KEY_W'(gen_mask), draw_rank(), i == 0);
            if ($urandom_range(0, 4) == 0)
                add_op(query_op(), KEY_W'($urandom_range(0, KEYS - 1)), draw_rank(), 1'b0);
        end

        // With the set full, the root counter and the rank walks are at their limits.
        add_op(OP_KTH_MIN, 10'd0,    10'd1023, 1'b1);
        add_op(OP_KTH_MAX, 10'd0,    10'd1023, 1'b0);
        add_op(OP_KTH_MIN, 10'd0,    10'd0,    1'b0);
        add_op(OP_MAX_XOR, 10'd0,    10'd0,    1'b0);
        add_op(OP_MIN_XOR, 10'd1023, 10'd0,    1'b0);
        add_op(OP_INSERT,  KEY_W'($urandom_range(0, KEYS - 1)), 10'd0, 1'b0);
        add_op(OP_XOR_ALL, KEY_W'($urandom_range(0, KEYS - 1)), 10'd0, 1'b0);
        add_op(OP_FIND,    KEY_W'($urandom_range(0, KEYS - 1)), 10'd0, 1'b0);

        // Random phases: the first one shrinks the full set, the rest are drawn.
        // A narrow key pool makes hits, duplicates and absent erases common.
        for (int ph = 0; ph < 5; ph++)
        begin
            kind   = (ph == 0) ? PH_SHRINK : $urandom_range(PH_GROW, PH_MIXED);
            narrow = $urandom_range(0, 1);
            base   = KEY_W'($urandom_range(0, KEYS - 1));
            for (int i = 0; i < 200; i++)
            begin
                k = narrow ? (base ^ KEY_W'($urandom_range(0, 15)))
                           : KEY_W'($urandom_range(0, KEYS - 1));
                pick = $urandom_range(0, 99);
                case (kind)
                    PH_GROW:   op = (pick < 55) ? OP_INSERT :
                                    (pick < 65) ? OP_ERASE : query_op();
                    PH_SHRINK: op = (pick < 15) ? OP_INSERT :
                                    (pick < 60) ? OP_ERASE : query_op();
                    default:   op = (pick < 30) ? OP_INSERT :
                                    (pick < 50) ? OP_ERASE : query_op();
                endcase
                add_op(op, k, draw_rank(), $urandom_range(0, 99) == 0);
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every operation to be transferred and every answer checked,
        // then give the block time to show any stray result.
        while (op_backlog.size() != 0 || in_valid || trie_answers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("xor_binary_trie_set_tb: clean");
        else
            $display("xor_binary_trie_set_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
